FILE: design/tgapsd_pkg.sv
// Shared types and constants for the TGA pixel stream decoder.
`default_nettype none
package tgapsd_pkg;

	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_RUN_LENGTH_MODE = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT    = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = CFG_INDEX_W'(3);

	localparam logic [1:0] FMT_GREY = 2'd0;
	localparam logic [1:0] FMT_BGR  = 2'd1;
	localparam logic [1:0] FMT_BGRA = 2'd2;

	// Decoding controls seen by the front end.
	typedef struct packed {
		logic       run_length_mode;
		logic [1:0] pixel_format;
	} fmt_cfg_t;

	// One decoded pixel before clipping against the image size.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] count;
	} pix_event_t;

endpackage
`default_nettype wire

FILE: design/tgapsd_if.sv
// Handshake channel interfaces for payload bytes, pixels and configuration writes.
`default_nettype none
interface tgapsd_byte_if import tgapsd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	modport source(output valid, output payload_byte, input ready);
	modport sink(input valid, input payload_byte, output ready);
endinterface

interface tgapsd_pixel_if import tgapsd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic [7:0] repeat_count;
	logic       last_pixel;
	modport source(output valid, output red, output green, output blue, output alpha,
		output repeat_count, output last_pixel, input ready);
	modport sink(input valid, input red, input green, input blue, input alpha,
		input repeat_count, input last_pixel, output ready);
endinterface

interface tgapsd_cfg_if import tgapsd_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: design/tgapsd_front.sv
// Front end: parses packet headers and assembles payload bytes into pixels.
`default_nettype none
module tgapsd_front import tgapsd_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire fmt_cfg_t     cfg,
	tgapsd_byte_if.sink       payload,
	output      logic         push_valid,
	output      pix_event_t   push_data,
	input  wire logic         push_ready
);

	logic       expect_q;
	logic       is_run_q;
	logic [7:0] left_q;
	logic [1:0] bip_q;
	logic [7:0] blue_q;
	logic [7:0] green_q;
	logic [7:0] red_q;

	logic       accept;
	logic       rle;
	logic       hdr;
	logic       complete;
	logic [7:0] b;
	logic [7:0] left_dec;
	logic [7:0] run_count;

	assign payload.ready = push_ready;
	assign accept        = payload.valid && push_ready;
	assign b             = payload.payload_byte;
	assign rle           = cfg.run_length_mode && (cfg.pixel_format != FMT_GREY);
	assign hdr           = rle && expect_q;

	always_comb begin
		unique case (cfg.pixel_format)
			FMT_GREY: complete = 1'b1;
			FMT_BGR:  complete = (bip_q >= 2'd2);
			default:  complete = (bip_q == 2'd3);
		endcase
	end

	// A run with an empty counter still counts once.
	assign run_count       = (left_q == 8'd0) ? 8'd1 : left_q;
	assign left_dec        = (left_q == 8'd0) ? 8'd0 : left_q - 8'd1;

	always_comb begin
		push_data.count = (rle && is_run_q) ? run_count : 8'd1;
		unique case (cfg.pixel_format)
			FMT_GREY: begin
				push_data.red   = b;
				push_data.green = 8'd0;
				push_data.blue  = 8'd0;
				push_data.alpha = 8'd0;
			end
			FMT_BGR: begin
				push_data.red   = b;
				push_data.green = green_q;
				push_data.blue  = blue_q;
				push_data.alpha = 8'd0;
			end
			default: begin
				push_data.red   = red_q;
				push_data.green = green_q;
				push_data.blue  = blue_q;
				push_data.alpha = b;
			end
		endcase
	end

	assign push_valid      = accept && !hdr && complete;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= 1'b1;
			is_run_q <= 1'b0;
			left_q   <= 8'd0;
			bip_q    <= 2'd0;
		end else if (accept) begin
			if (hdr) begin
				is_run_q <= b[7];
				left_q   <= b[7] ? b - 8'd127 : b + 8'd1;
				expect_q <= 1'b0;
				bip_q    <= 2'd0;
			end else if (!complete) begin
				bip_q <= bip_q + 2'd1;
			end else begin
				bip_q <= 2'd0;
				if (rle) begin
					if (is_run_q) begin
						left_q   <= 8'd0;
						expect_q <= 1'b1;
					end else begin
						left_q   <= left_dec;
						expect_q <= (left_dec == 8'd0);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blue_q  <= 8'd0;
			green_q <= 8'd0;
			red_q   <= 8'd0;
		end else if (accept && !hdr && !complete) begin
			case (bip_q)
				2'd0:    blue_q  <= b;
				2'd1:    green_q <= b;
				default: red_q   <= b;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/tgapsd_queue.sv
// Short first-in first-out queue of decoded pixels between front and back end.
`default_nettype none
module tgapsd_queue import tgapsd_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push_valid,
	input  wire pix_event_t push_data,
	output      logic       push_ready,
	output      logic       pop_valid,
	output      pix_event_t pop_data,
	input  wire logic       pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pix_event_t             mem_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != CNT_W'(0));
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

FILE: design/tgapsd_back.sv
// Back end: clips repeat counts to the image size, tracks completion and drives the output.
`default_nettype none
module tgapsd_back import tgapsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] total,
	input  wire logic        byte_taken,
	input  wire logic        head_valid,
	input  wire pix_event_t  head_data,
	output      logic        pop,
	tgapsd_pixel_if.source   pixel
);

	logic [31:0] emitted_q;
	logic        done_q;
	logic        valid_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic [7:0]  alpha_q;
	logic [7:0]  count_q;
	logic        last_q;

	logic [31:0] remaining;
	logic        rem_zero;
	logic        clip;
	logic        drop;
	logic        load;
	logic [7:0]  count_c;

	assign rem_zero  = !(total > emitted_q);
	assign remaining = total - emitted_q;
	assign clip      = ({24'd0, head_data.count} >= remaining);
	assign count_c   = clip ? remaining[7:0] : head_data.count;
	assign drop      = done_q || rem_zero;
	assign pop       = head_valid && (drop || !valid_q || pixel.ready);
	assign load      = pop && !drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emitted_q <= 32'd0;
			done_q    <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			if (pop && !done_q) begin
				if (rem_zero) begin
					done_q <= 1'b1;
				end else begin
					emitted_q <= clip ? total : emitted_q + 32'(head_data.count);
					done_q    <= clip;
				end
			end else if (byte_taken && rem_zero) begin
				// Any byte that arrives once the image is covered closes it for good.
				done_q <= 1'b1;
			end
			if (load) valid_q <= 1'b1;
			else if (pixel.ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			red_q   <= head_data.red;
			green_q <= head_data.green;
			blue_q  <= head_data.blue;
			alpha_q <= head_data.alpha;
			count_q <= count_c;
			last_q  <= clip;
		end
	end

	assign pixel.valid        = valid_q;
	assign pixel.red          = red_q;
	assign pixel.green        = green_q;
	assign pixel.blue         = blue_q;
	assign pixel.alpha        = alpha_q;
	assign pixel.repeat_count = count_q;
	assign pixel.last_pixel   = last_q;

endmodule
`default_nettype wire

FILE: design/tga_pixel_stream_decoder.sv
// Top level of the TGA pixel stream decoder: configuration registers and the three stages.
//
// The decoder takes one payload byte per clock cycle as long as the output is taken and
// emits each completed pixel as R, G, B, A with a repeat count, clipped to the pixels the
// image still needs; last_pixel marks the result that completes the image, and bytes after
// it are dropped until reset. A byte enters the front end in the cycle it is offered if the
// pixel queue has room, and a completed pixel passes through that queue into the output
// register; when the output stalls, the pixel queue (QUEUE_DEPTH entries, at least two)
// absorbs pixels before the byte input is held off. Configuration writes are always
// accepted and should be made only while no pixel is in flight.
`default_nettype none
module tga_pixel_stream_decoder import tgapsd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	tgapsd_cfg_if.sink     cfg,
	tgapsd_byte_if.sink    payload,
	tgapsd_pixel_if.source pixel
);

	logic        run_length_mode_q;
	logic [1:0]  pixel_format_q;
	logic [15:0] image_width_q;
	logic [15:0] image_height_q;
	logic [31:0] total_q;

	logic [15:0] width_next;
	logic [15:0] height_next;
	logic        byte_taken;
	fmt_cfg_t    fmt_cfg;
	logic        push_valid;
	pix_event_t  push_data;
	logic        push_ready;
	logic        head_valid;
	pix_event_t  head_data;
	logic        pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_mode_q <= 1'b0;
			pixel_format_q    <= FMT_BGR;
			image_width_q     <= 16'd1;
			image_height_q    <= 16'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_RUN_LENGTH_MODE: run_length_mode_q <= cfg.data[0];
				REG_PIXEL_FORMAT:    pixel_format_q    <= cfg.data[1:0];
				REG_IMAGE_WIDTH:     image_width_q     <= cfg.data;
				REG_IMAGE_HEIGHT:    image_height_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	assign width_next  = (cfg.valid && (cfg.index == REG_IMAGE_WIDTH)) ? cfg.data
		: image_width_q;
	assign height_next = (cfg.valid && (cfg.index == REG_IMAGE_HEIGHT)) ? cfg.data
		: image_height_q;

	// The pixel total is taken from the incoming size values, so it changes on the same
	// edge as the size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) total_q <= 32'd1;
		else total_q <= 32'(width_next) * 32'(height_next);
	end

	assign byte_taken = payload.valid && payload.ready;

	assign fmt_cfg.run_length_mode = run_length_mode_q;
	assign fmt_cfg.pixel_format    = pixel_format_q;

	tgapsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (fmt_cfg),
		.payload    (payload),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	tgapsd_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (head_valid),
		.pop_data   (head_data),
		.pop        (pop)
	);

	tgapsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.total      (total_q),
		.byte_taken (byte_taken),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.pixel      (pixel)
	);

endmodule
`default_nettype wire
